[rtl/core/qrq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrq_pkg
// Shared types and constants for the rotated 4-D group quantizer.
// ----------------------------------------------------------------------------
package qrq_pkg;

	// default table sizes
	localparam int MAX_GROUPS_DEF = 32;
	localparam int MAX_LEVELS_DEF = 16;

	// fixed field widths
	localparam int SAMPLE_W  = 16;
	localparam int IDX_W     = 7;
	localparam int OP_W      = 2;
	localparam int GIDX_W    = 5;
	localparam int LEN_W     = 8;
	localparam int LVL_CFG_W = 5;
	localparam int APB_AW    = 3;
	localparam int APB_DW    = 32;

	// register reset values
	localparam logic [LEN_W-1:0]     EMB_LEN_RST = 8'd128;
	localparam logic [LVL_CFG_W-1:0] LVL_CNT_RST = 5'd16;

	// item operation codes
	typedef enum logic [OP_W-1:0] {
		OP_QUANT  = 2'd0,
		OP_ROT_WR = 2'd1,
		OP_CEN_WR = 2'd2
	} op_t;

	// register indexes on the configuration port
	typedef enum logic {
		REG_EMB_LEN = 1'b0,
		REG_LVL_CNT = 1'b1
	} reg_idx_t;

	// control that travels with every item down the pipeline
	typedef struct packed {
		logic                valid;
		op_t                 op;
		logic [IDX_W-1:0]    idx;
		logic [SAMPLE_W-1:0] word;
		logic [3:0]          lane_on;
	} ctl_t;

endpackage
`default_nettype wire

[rtl/core/quaternion_rotate_quantize_group.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quaternion_rotate_quantize_group
// Group-of-four rotated scalar quantizer with table load ops.
// ----------------------------------------------------------------------------
// One item is taken in every cycle (busy stays low) and a quantize item gives
// its result on done, one result per cycle at most; the receiver cannot stall.
// The pipeline runs through the norm square root (32 stages, one root bit
// each) and the normalizing divider (15 stages, one quotient bit each),
// followed by the two quaternion products, the centroid search and the
// rescale. Table writes travel down the pipeline with the quantize items and
// take effect in item order.
// ----------------------------------------------------------------------------
module quaternion_rotate_quantize_group #(
	parameter int MAX_GROUPS = qrq_pkg::MAX_GROUPS_DEF,
	parameter int MAX_LEVELS = qrq_pkg::MAX_LEVELS_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	// item channel
	input  wire logic                             start,
	output logic                                  busy,
	input  wire logic [qrq_pkg::OP_W-1:0]         op,
	input  wire logic [qrq_pkg::IDX_W-1:0]        index,
	input  wire logic signed [qrq_pkg::SAMPLE_W-1:0] x0,
	input  wire logic signed [qrq_pkg::SAMPLE_W-1:0] x1,
	input  wire logic signed [qrq_pkg::SAMPLE_W-1:0] x2,
	input  wire logic signed [qrq_pkg::SAMPLE_W-1:0] x3,
	input  wire logic signed [qrq_pkg::SAMPLE_W-1:0] load_value,
	// result channel
	output logic                                  done,
	output logic [qrq_pkg::GIDX_W-1:0]            group_index,
	output logic signed [qrq_pkg::SAMPLE_W-1:0]   y0,
	output logic signed [qrq_pkg::SAMPLE_W-1:0]   y1,
	output logic signed [qrq_pkg::SAMPLE_W-1:0]   y2,
	output logic signed [qrq_pkg::SAMPLE_W-1:0]   y3,
	// configuration port
	input  wire logic                             psel,
	input  wire logic                             penable,
	input  wire logic                             pwrite,
	input  wire logic [qrq_pkg::APB_AW-1:0]       paddr,
	input  wire logic [qrq_pkg::APB_DW-1:0]       pwdata,
	output logic [qrq_pkg::APB_DW-1:0]            prdata,
	output logic                                  pready
);
	import qrq_pkg::*;

	localparam int ROT_DEPTH = 4 * MAX_GROUPS;
	localparam int GRP_W     = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int LVL_IDX_W = $clog2(MAX_LEVELS);
	localparam int SQ_N      = 32;
	localparam int DIV_N     = 15;
	localparam int DV_W      = 47;
	localparam int R_W       = 20;
	localparam int SUM_W     = 34;
	localparam int YM_W      = 53;
	localparam int ST_RT_END = 3 + SQ_N;
	localparam int ST_DV_END = ST_RT_END + 1 + DIV_N;
	localparam int ST_R      = ST_DV_END + 3;
	localparam int LAST      = ST_DV_END + 8;

	// configuration registers
	logic [LEN_W-1:0]     emb_len_q;
	logic [LVL_CFG_W-1:0] lvl_cnt_q;

	// control chain
	ctl_t ctl_in;
	ctl_t ctl_s [1:LAST];

	// data stages
	logic signed [SAMPLE_W-1:0] x_s1 [4];
	logic signed [SAMPLE_W-1:0] x_s2 [4];
	logic [30:0]                sq_s2 [4];
	logic signed [31:0]         sqp [4];
	logic [32:0]                sum_s2;

	logic [63:0]                sqv_s [SQ_N+1];
	logic [63:0]                sqr_s [SQ_N+1];
	logic [63:0]                sqv_nx [SQ_N];
	logic [63:0]                sqr_nx [SQ_N];
	logic signed [SAMPLE_W-1:0] sqx_s [SQ_N+1][4];
	logic                       sqz_s [SQ_N+1];

	logic [31:0]                n_init;
	logic [DV_W-1:0]            num_init [4];
	logic [DV_W-1:0]            dv_rem_s [DIV_N+1][4];
	logic [DIV_N-1:0]           dv_q_s [DIV_N+1][4];
	logic [3:0]                 dv_sign_s [DIV_N+1];
	logic [31:0]                dv_n_s [DIV_N+1];
	logic [DV_W-1:0]            dv_rem_nx [DIV_N][4];
	logic [DIV_N-1:0]           dv_q_nx [DIV_N][4];

	logic signed [SAMPLE_W-1:0] u_s52 [4];
	logic signed [SAMPLE_W-1:0] q_s52 [4];
	logic [31:0]                n_s52;
	logic signed [31:0]         p1_s53 [4][4];
	logic signed [SAMPLE_W-1:0] q_s53 [4];
	logic [31:0]                n_s53;
	logic signed [R_W-1:0]      r_nx [4];
	logic signed [R_W-1:0]      r_s54 [4];
	logic signed [SAMPLE_W-1:0] q_s54 [4];
	logic [31:0]                n_s54;
	logic signed [SAMPLE_W-1:0] cen_q [MAX_LEVELS];
	logic [LVL_IDX_W-1:0]       lvl_top;
	logic signed [SAMPLE_W-1:0] c_nx [4];
	logic signed [SAMPLE_W-1:0] c_s55 [4];
	logic signed [SAMPLE_W-1:0] q_s55 [4];
	logic [31:0]                n_s55;
	logic signed [31:0]         p2_s56 [4][4];
	logic [31:0]                n_s56;
	logic signed [R_W-1:0]      w_nx [4];
	logic signed [R_W-1:0]      w_s57 [4];
	logic [31:0]                n_s57;
	logic signed [YM_W-1:0]     ym_s58 [4];
	logic signed [SAMPLE_W-1:0] y_nx [4];
	logic signed [SAMPLE_W-1:0] y_s59 [4];

	logic [GRP_W-1:0]           rot_row;

	// the pipeline never stalls
	assign busy   = 1'b0;
	assign pready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emb_len_q <= EMB_LEN_RST;
			lvl_cnt_q <= LVL_CNT_RST;
		end else if (psel && penable && pwrite && pready) begin
			case (reg_idx_t'(paddr[2]))
				REG_EMB_LEN: emb_len_q <= pwdata[LEN_W-1:0];
				REG_LVL_CNT: lvl_cnt_q <= pwdata[LVL_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// configuration reads
	always_comb begin
		case (reg_idx_t'(paddr[2]))
			REG_EMB_LEN: prdata = APB_DW'(emb_len_q);
			REG_LVL_CNT: prdata = APB_DW'(lvl_cnt_q);
			default:     prdata = '0;
		endcase
	end

	// item decode: out-of-range ops and indexes become bubbles
	always_comb begin
		ctl_in.op   = op_t'(op);
		ctl_in.idx  = index;
		ctl_in.word = load_value;
		for (int i = 0; i < 4; i++) begin
			ctl_in.lane_on[i] = (({2'b00, index} << 2) + 9'(i)) < {1'b0, emb_len_q};
		end
		ctl_in.valid = start && !busy &&
			((op == OP_QUANT  && int'(index) < MAX_GROUPS) ||
			 (op == OP_ROT_WR && int'(index) < ROT_DEPTH) ||
			 (op == OP_CEN_WR && int'(index) < MAX_LEVELS));
	end

	// control chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= LAST; k++) ctl_s[k] <= '0;
		end else begin
			ctl_s[1] <= ctl_in;
			for (int k = 2; k <= LAST; k++) ctl_s[k] <= ctl_s[k-1];
		end
	end

	// squares and their sum
	always_comb begin
		for (int i = 0; i < 4; i++) sqp[i] = x_s1[i] * x_s1[i];
		sum_s2 = 33'(sq_s2[0]) + 33'(sq_s2[1]) + 33'(sq_s2[2]) + 33'(sq_s2[3]);
	end

	// square root, one root bit a stage
	always_comb begin
		logic [63:0] bitk;
		logic [63:0] trial;
		for (int j = 0; j < SQ_N; j++) begin
			bitk  = 64'd1 << (62 - 2 * j);
			trial = sqr_s[j] + bitk;
			if (sqv_s[j] >= trial) begin
				sqv_nx[j] = sqv_s[j] - trial;
				sqr_nx[j] = (sqr_s[j] >> 1) + bitk;
			end else begin
				sqv_nx[j] = sqv_s[j];
				sqr_nx[j] = sqr_s[j] >> 1;
			end
		end
	end

	// norm and rounded dividends
	always_comb begin
		logic [SAMPLE_W-1:0] xu;
		logic [SAMPLE_W-1:0] mag;
		n_init = sqz_s[SQ_N] ? 32'h0000_8000 : sqr_s[SQ_N][31:0];
		for (int i = 0; i < 4; i++) begin
			xu  = sqx_s[SQ_N][i];
			mag = xu[SAMPLE_W-1] ? (~xu + 16'd1) : xu;
			num_init[i] = (DV_W'(mag) << 29) + DV_W'(n_init >> 1);
		end
	end

	// restoring divider, one quotient bit a stage
	always_comb begin
		logic [DV_W-1:0] d;
		for (int k = 0; k < DIV_N; k++) begin
			for (int l = 0; l < 4; l++) begin
				d = DV_W'(dv_n_s[k]) << (DIV_N - 1 - k);
				if (dv_rem_s[k][l] >= d) begin
					dv_rem_nx[k][l] = dv_rem_s[k][l] - d;
					dv_q_nx[k][l]   = dv_q_s[k][l] | (DIV_N'(1) << (DIV_N - 1 - k));
				end else begin
					dv_rem_nx[k][l] = dv_rem_s[k][l];
					dv_q_nx[k][l]   = dv_q_s[k][l];
				end
			end
		end
	end

	// rotation table: one bank per quaternion component, a row per group
	assign rot_row = (ctl_s[ST_DV_END].op == OP_ROT_WR) ?
		GRP_W'(ctl_s[ST_DV_END].idx >> 2) : GRP_W'(ctl_s[ST_DV_END].idx);

	for (genvar b = 0; b < 4; b++) begin : g_rot_bank
		logic [SAMPLE_W-1:0] rot_mem [MAX_GROUPS];
		always_ff @(posedge clk) begin
			if (ctl_s[ST_DV_END].valid && ctl_s[ST_DV_END].op == OP_ROT_WR &&
			    ctl_s[ST_DV_END].idx[1:0] == 2'(b)) begin
				rot_mem[rot_row] <= ctl_s[ST_DV_END].word;
			end
			q_s52[b] <= rot_mem[rot_row];
		end
	end

	// rotate: q * u, rounded
	always_comb begin
		logic signed [SUM_W-1:0] t [4];
		t[0] = SUM_W'(p1_s53[0][0]) - SUM_W'(p1_s53[1][1]) - SUM_W'(p1_s53[2][2])
		     - SUM_W'(p1_s53[3][3]);
		t[1] = SUM_W'(p1_s53[0][1]) + SUM_W'(p1_s53[1][0]) + SUM_W'(p1_s53[2][3])
		     - SUM_W'(p1_s53[3][2]);
		t[2] = SUM_W'(p1_s53[0][2]) - SUM_W'(p1_s53[1][3]) + SUM_W'(p1_s53[2][0])
		     + SUM_W'(p1_s53[3][1]);
		t[3] = SUM_W'(p1_s53[0][3]) + SUM_W'(p1_s53[1][2]) - SUM_W'(p1_s53[2][1])
		     + SUM_W'(p1_s53[3][0]);
		for (int l = 0; l < 4; l++) r_nx[l] = R_W'((t[l] + SUM_W'(8192)) >>> 14);
	end

	// last usable centroid index
	always_comb begin
		if (lvl_cnt_q == '0) lvl_top = '0;
		else if (int'(lvl_cnt_q) > MAX_LEVELS) lvl_top = LVL_IDX_W'(MAX_LEVELS - 1);
		else lvl_top = LVL_IDX_W'(lvl_cnt_q - 5'd1);
	end

	// snap: midpoint compares, then binary search over them
	always_comb begin
		logic signed [R_W:0]      rr2;
		logic [MAX_LEVELS-1:0]    ge;
		logic [LVL_IDX_W-1:0]     lo;
		logic [LVL_IDX_W-1:0]     hi;
		logic [LVL_IDX_W-1:0]     mid;
		for (int l = 0; l < 4; l++) begin
			rr2 = {r_s54[l], 1'b0};
			ge  = '0;
			for (int m = 0; m < MAX_LEVELS - 1; m++) begin
				ge[m] = rr2 >= ((R_W+1)'(cen_q[m]) + (R_W+1)'(cen_q[m+1]));
			end
			lo  = '0;
			hi  = lvl_top;
			mid = '0;
			for (int s = 0; s < LVL_IDX_W; s++) begin
				if (lo < hi) begin
					mid = LVL_IDX_W'(({1'b0, lo} + {1'b0, hi}) >> 1);
					if (ge[mid]) lo = mid + 1'b1;
					else hi = mid;
				end
			end
			c_nx[l] = cen_q[lo];
		end
	end

	// centroid table writes, in item order at the search stage
	always_ff @(posedge clk) begin
		if (ctl_s[ST_R].valid && ctl_s[ST_R].op == OP_CEN_WR) begin
			cen_q[LVL_IDX_W'(ctl_s[ST_R].idx)] <= ctl_s[ST_R].word;
		end
	end

	// unrotate: conj(q) * c, rounded
	always_comb begin
		logic signed [SUM_W-1:0] t [4];
		t[0] = SUM_W'(p2_s56[0][0]) + SUM_W'(p2_s56[1][1]) + SUM_W'(p2_s56[2][2])
		     + SUM_W'(p2_s56[3][3]);
		t[1] = SUM_W'(p2_s56[0][1]) - SUM_W'(p2_s56[1][0]) - SUM_W'(p2_s56[2][3])
		     + SUM_W'(p2_s56[3][2]);
		t[2] = SUM_W'(p2_s56[0][2]) + SUM_W'(p2_s56[1][3]) - SUM_W'(p2_s56[2][0])
		     - SUM_W'(p2_s56[3][1]);
		t[3] = SUM_W'(p2_s56[0][3]) - SUM_W'(p2_s56[1][2]) + SUM_W'(p2_s56[2][1])
		     - SUM_W'(p2_s56[3][0]);
		for (int l = 0; l < 4; l++) w_nx[l] = R_W'((t[l] + SUM_W'(8192)) >>> 14);
	end

	// rescale, saturate and zero the lanes past the length
	always_comb begin
		logic signed [YM_W-1:0] t;
		logic signed [YM_W-30:0] ys;
		for (int l = 0; l < 4; l++) begin
			t  = ym_s58[l] + YM_W'(64'd1 << 28);
			ys = (YM_W-29)'(t >>> 29);
			if (!ctl_s[LAST-1].lane_on[l]) y_nx[l] = '0;
			else if (ys > (YM_W-29)'(32767)) y_nx[l] = 16'sh7FFF;
			else if (ys < -(YM_W-29)'(32768)) y_nx[l] = -16'sh8000;
			else y_nx[l] = SAMPLE_W'(ys);
		end
	end

	// data pipeline
	always_ff @(posedge clk) begin
		// stage 1: masked samples
		x_s1[0] <= ctl_in.lane_on[0] ? x0 : '0;
		x_s1[1] <= ctl_in.lane_on[1] ? x1 : '0;
		x_s1[2] <= ctl_in.lane_on[2] ? x2 : '0;
		x_s1[3] <= ctl_in.lane_on[3] ? x3 : '0;
		// stage 2: squares
		for (int i = 0; i < 4; i++) begin
			sq_s2[i] <= sqp[i][30:0];
			x_s2[i]  <= x_s1[i];
		end
		// stage 3: radicand
		sqv_s[0] <= 64'(sum_s2) << 30;
		sqr_s[0] <= '0;
		sqx_s[0] <= x_s2;
		sqz_s[0] <= (sum_s2 == '0);
		// root stages
		for (int j = 0; j < SQ_N; j++) begin
			sqv_s[j+1] <= sqv_nx[j];
			sqr_s[j+1] <= sqr_nx[j];
			sqx_s[j+1] <= sqx_s[j];
			sqz_s[j+1] <= sqz_s[j];
		end
		// divider entry
		dv_n_s[0] <= n_init;
		for (int l = 0; l < 4; l++) begin
			dv_rem_s[0][l]  <= num_init[l];
			dv_q_s[0][l]    <= '0;
			dv_sign_s[0][l] <= sqx_s[SQ_N][l][SAMPLE_W-1];
		end
		// divider stages
		for (int k = 0; k < DIV_N; k++) begin
			dv_rem_s[k+1]  <= dv_rem_nx[k];
			dv_q_s[k+1]    <= dv_q_nx[k];
			dv_sign_s[k+1] <= dv_sign_s[k];
			dv_n_s[k+1]    <= dv_n_s[k];
		end
		// unit vector
		for (int l = 0; l < 4; l++) begin
			if (dv_sign_s[DIV_N][l]) u_s52[l] <= -$signed({1'b0, dv_q_s[DIV_N][l]});
			else u_s52[l] <= $signed({1'b0, dv_q_s[DIV_N][l]});
		end
		n_s52 <= dv_n_s[DIV_N];
		// rotate products
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) p1_s53[i][j] <= q_s52[i] * u_s52[j];
		end
		q_s53 <= q_s52;
		n_s53 <= n_s52;
		// rotated vector
		r_s54 <= r_nx;
		q_s54 <= q_s53;
		n_s54 <= n_s53;
		// snapped vector
		c_s55 <= c_nx;
		q_s55 <= q_s54;
		n_s55 <= n_s54;
		// unrotate products
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) p2_s56[i][j] <= q_s55[i] * c_s55[j];
		end
		n_s56 <= n_s55;
		// unrotated vector
		w_s57 <= w_nx;
		n_s57 <= n_s56;
		// rescale products
		for (int l = 0; l < 4; l++) ym_s58[l] <= w_s57[l] * $signed({1'b0, n_s57});
		// output
		y_s59 <= y_nx;
	end

	// result ports
	assign done        = ctl_s[LAST].valid && ctl_s[LAST].op == OP_QUANT;
	assign group_index = ctl_s[LAST].idx[GIDX_W-1:0];
	assign y0          = y_s59[0];
	assign y1          = y_s59[1];
	assign y2          = y_s59[2];
	assign y3          = y_s59[3];

	// every accepted quantize item gives a result on done at the end of the pipeline
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && op == OP_QUANT && int'(index) < MAX_GROUPS) |-> ##(LAST) done)
		else $error("quantize item lost in pipeline");

	// root remainder stays within the isqrt bound
	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[ST_RT_END].valid |-> sqv_s[SQ_N] <= (sqr_s[SQ_N] << 1))
		else $error("square root remainder out of range");

	// divider remainders end below the norm
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_s[ST_DV_END].valid |->
			(dv_rem_s[DIV_N][0] < DV_W'(dv_n_s[DIV_N])) &&
			(dv_rem_s[DIV_N][1] < DV_W'(dv_n_s[DIV_N])) &&
			(dv_rem_s[DIV_N][2] < DV_W'(dv_n_s[DIV_N])) &&
			(dv_rem_s[DIV_N][3] < DV_W'(dv_n_s[DIV_N])))
		else $error("divider remainder not below divisor");

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rotated group quantizer: loads the rotation and
// centroid tables, runs directed and random items over several register
// settings and idle patterns, and compares every result with a predicted one.
// ----------------------------------------------------------------------------
import qrq_pkg::*;

typedef struct {
	logic [1:0]         op;
	logic [6:0]         index;
	logic signed [15:0] x[4];
	logic signed [15:0] load_value;
} quant_item_t;

typedef struct {
	logic [4:0]         group_index;
	logic signed [15:0] y[4];
} quant_result_t;

// predicted group reconstructions, oldest first
class quant_scoreboard;
	logic signed [15:0] rot_tab[128];
	logic signed [15:0] cen_tab[16];
	int unsigned emb_len = 128;
	int unsigned lvl_cnt = 16;
	quant_result_t recon_q[$];
	int mismatches = 0;

	function longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// round half up, then drop sh bits
	function longint round_down(longint t, int sh);
		return (t + (64'sd1 <<< (sh - 1))) >>> sh;
	endfunction

	function void hamilton(longint a[4], longint b[4], output longint r[4]);
		r[0] = round_down(a[0]*b[0] - a[1]*b[1] - a[2]*b[2] - a[3]*b[3], 14);
		r[1] = round_down(a[0]*b[1] + a[1]*b[0] + a[2]*b[3] - a[3]*b[2], 14);
		r[2] = round_down(a[0]*b[2] - a[1]*b[3] + a[2]*b[0] + a[3]*b[1], 14);
		r[3] = round_down(a[0]*b[3] + a[1]*b[2] - a[2]*b[1] + a[3]*b[0], 14);
	endfunction

	// binary search over midpoints, a tie goes up
	function longint nearest_level(longint v, int unsigned levels);
		int unsigned lo, hi, mid;
		lo = 0;
		hi = levels - 1;
		while (lo < hi) begin
			mid = (lo + hi) / 2;
			if (2 * v < longint'(cen_tab[mid]) + longint'(cen_tab[mid + 1])) hi = mid;
			else lo = mid + 1;
		end
		return cen_tab[lo];
	endfunction

	function void note_item(quant_item_t it);
		longint xs[4], u[4], q[4], qc[4], r[4], c[4], w[4], y;
		longint unsigned s, n, mag;
		int unsigned levels;
		quant_result_t res;
		if (it.op == OP_ROT_WR) begin
			rot_tab[it.index] = it.load_value;
			return;
		end
		if (it.op == OP_CEN_WR) begin
			if (it.index < 16) cen_tab[it.index] = it.load_value;
			return;
		end
		if (it.op != OP_QUANT || it.index >= 32) return;
		s = 0;
		for (int i = 0; i < 4; i++) begin
			xs[i] = (it.index * 4 + i < emb_len) ? longint'(it.x[i]) : 0;
			s = s + longint'(xs[i] * xs[i]);
		end
		n = (s == 0) ? (64'd1 << 15) : int_sqrt(s << 30);
		for (int i = 0; i < 4; i++) begin
			mag = longint'(xs[i] < 0 ? -xs[i] : xs[i]) << 29;
			u[i] = (mag + n / 2) / n;
			if (xs[i] < 0) u[i] = -u[i];
			q[i] = rot_tab[it.index * 4 + i];
			qc[i] = (i == 0) ? q[i] : -q[i];
		end
		levels = (lvl_cnt == 0) ? 1 : (lvl_cnt > 16 ? 16 : lvl_cnt);
		hamilton(q, u, r);
		for (int i = 0; i < 4; i++) c[i] = nearest_level(r[i], levels);
		hamilton(qc, c, w);
		res.group_index = it.index[4:0];
		for (int i = 0; i < 4; i++) begin
			y = round_down(w[i] * longint'(n), 29);
			if (y > 32767) y = 32767;
			if (y < -32768) y = -32768;
			if (it.index * 4 + i >= emb_len) y = 0;
			res.y[i] = y[15:0];
		end
		recon_q.push_back(res);
	endfunction

	function void report(string what);
		mismatches++;
		if (mismatches <= 10) $display("mismatch: %s", what);
	endfunction

	function void check_result(quant_result_t got);
		quant_result_t exp_r;
		if (recon_q.size() == 0) begin
			report($sformatf("unexpected result for group %0d", got.group_index));
			return;
		end
		exp_r = recon_q.pop_front();
		if (got.group_index != exp_r.group_index)
			report($sformatf("group_index expected %0d got %0d",
				exp_r.group_index, got.group_index));
		for (int i = 0; i < 4; i++)
			if (got.y[i] !== exp_r.y[i])
				report($sformatf("group %0d y%0d expected %0d got %0d",
					exp_r.group_index, i, exp_r.y[i], got.y[i]));
	endfunction
endclass

module tb;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 80;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] op = '0;
	logic [6:0] index = '0;
	logic signed [15:0] x0 = '0, x1 = '0, x2 = '0, x3 = '0, load_value = '0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [APB_DW-1:0] pwdata = '0;
	wire busy, done, pready;
	wire [4:0] group_index;
	wire signed [15:0] y0, y1, y2, y3;
	wire [APB_DW-1:0] prdata;

	quant_scoreboard sb = new();
	int idle_pct = 0;
	int stall_count = 0;

	quaternion_rotate_quantize_group dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op),
		.index(index), .x0(x0), .x1(x1), .x2(x2), .x3(x3),
		.load_value(load_value), .done(done), .group_index(group_index),
		.y0(y0), .y1(y1), .y2(y2), .y3(y3), .psel(psel), .penable(penable),
		.pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
		.pready(pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result monitor
	always @(posedge clk) begin
		quant_result_t got;
		if (done) begin
			got.group_index = group_index;
			got.y[0] = y0;
			got.y[1] = y1;
			got.y[2] = y2;
			got.y[3] = y3;
			sb.check_result(got);
		end
	end

	// watchdog on cycles with no item or result moving
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) stall_count <= 0;
			else stall_count <= stall_count + 1;
			if (stall_count >= WATCHDOG_LIMIT) begin
				$display("quaternion_rotate_quantize_group test failed");
				$finish;
			end
		end
	end

	// register write then read back
	task automatic reg_write(reg_idx_t ri, logic [31:0] val);
		paddr <= {ri, 2'b00};
		pwdata <= val;
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		pwrite <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (ri == REG_EMB_LEN && prdata[7:0] !== val[7:0])
			sb.report($sformatf("embedding_length read %0d", prdata));
		if (ri == REG_LVL_CNT && prdata[4:0] !== val[4:0])
			sb.report($sformatf("level_count read %0d", prdata));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (ri == REG_EMB_LEN) sb.emb_len = val[7:0];
		else sb.lvl_cnt = val[4:0];
	endtask

	task automatic send_item(quant_item_t it);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		start <= 1'b1;
		op <= it.op;
		index <= it.index;
		x0 <= it.x[0];
		x1 <= it.x[1];
		x2 <= it.x[2];
		x3 <= it.x[3];
		load_value <= it.load_value;
		do @(posedge clk); while (busy);
		sb.note_item(it);
	endtask

	task automatic load(logic [1:0] o, int idx, int val);
		quant_item_t it;
		it.op = o;
		it.index = 7'(idx);
		it.load_value = 16'(val);
		for (int i = 0; i < 4; i++) it.x[i] = 16'($urandom);
		send_item(it);
	endtask

	task automatic quant(int g, int a, int b, int c, int d);
		quant_item_t it;
		it.op = OP_QUANT;
		it.index = 7'(g);
		it.x[0] = 16'(a);
		it.x[1] = 16'(b);
		it.x[2] = 16'(c);
		it.x[3] = 16'(d);
		it.load_value = 16'($urandom);
		send_item(it);
	endtask

	// let the pipeline empty, including table writes still in flight
	task automatic drain();
		start <= 1'b0;
		while (sb.recon_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic load_sorted_centroids();
		int v[16];
		for (int k = 0; k < 16; k++) v[k] = $signed(16'($urandom));
		v.sort();
		for (int k = 0; k < 16; k++) load(OP_CEN_WR, k, v[k]);
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(5))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return $signed(16'($urandom_range(0, 15))) - 16'sd8;
			3: return 16'sd0;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_item();
		quant_item_t it;
		int pick;
		pick = $urandom_range(99);
		it.load_value = 16'($urandom);
		for (int i = 0; i < 4; i++) it.x[i] = rand_sample();
		if (pick < 80) begin
			it.op = OP_QUANT;
			it.index = 7'($urandom_range(0, 31));
		end else if (pick < 86) begin
			it.op = OP_ROT_WR;
			it.index = 7'($urandom);
		end else if (pick < 90) begin
			it.op = OP_CEN_WR;
			it.index = 7'($urandom);
		end else if (pick < 95) begin
			it.op = OP_QUANT;
			it.index = 7'($urandom_range(32, 127));
		end else begin
			it.op = OP_UNUSED;
			it.index = 7'($urandom);
		end
		send_item(it);
	endtask

	initial begin
		int emb_set[6] = '{128, 1, 37, 128, 0, 0};
		int lvl_set[6] = '{16, 1, 16, 2, 0, 0};
		int pct_set[6] = '{0, 81, 81, 22, 0, 22};
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// tables: identity and axis quaternions for the first groups
		for (int w = 0; w < 128; w++) begin
			if (w < 4) load(OP_ROT_WR, w, (w == 0) ? 16384 : 0);
			else if (w < 8) load(OP_ROT_WR, w, (w == 5) ? 16384 : 0);
			else load(OP_ROT_WR, w, $signed(16'($urandom)));
		end
		// symmetric levels so that a zero component sits on a midpoint
		for (int k = 0; k < 16; k++) load(OP_CEN_WR, k, (k - 7) * 2048 - 1024);
		drain();
		reg_write(REG_EMB_LEN, 128);
		reg_write(REG_LVL_CNT, 16);

		// directed items
		quant(0, 0, 0, 0, 0);
		quant(0, 100, 0, 0, 0);
		quant(0, 0, -100, 0, 0);
		quant(0, 32767, 32767, 32767, 32767);
		quant(0, -32768, -32768, -32768, -32768);
		quant(1, -32768, 32767, -32768, 32767);
		quant(1, 1, 0, 0, 0);
		quant(2, -1, 1, -1, 1);
		quant(31, 32767, -32768, 0, 12345);
		quant(40, 5, 5, 5, 5);
		load(OP_UNUSED, 3, 16'sh7fff);
		load(OP_CEN_WR, 20, 16'sh8000);
		quant(5, 1000, -2000, 3000, -4000);
		quant(0, 7, 0, 0, 0);
		drain();

		// phases of register settings and idle patterns
		for (int p = 0; p < 6; p++) begin
			int e, l;
			e = (p >= 4) ? $urandom_range(1, 128) : emb_set[p];
			l = (p >= 4) ? $urandom_range(1, 16) : lvl_set[p];
			reg_write(REG_EMB_LEN, e);
			reg_write(REG_LVL_CNT, l);
			idle_pct = pct_set[p];
			if (p == 3) load_sorted_centroids();
			for (int n = 0; n < 100; n++) begin
				random_item();
				// now and then the sender waits for every result
				if (n == 60) drain();
			end
			drain();
		end

		if (sb.mismatches == 0) $display("quaternion_rotate_quantize_group test passed");
		else $display("quaternion_rotate_quantize_group test failed");
		$finish;
	end
endmodule
